// ===== design/tmcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmcr_pkg
// Shared types, constants and the colour palette of the text mode cell
// renderer.
// ----------------------------------------------------------------------------
package tmcr_pkg;

	localparam int MAX_COLUMNS_DEF = 128;
	localparam int MAX_ROWS_DEF    = 48;
	localparam int FONT_CHARS_DEF  = 256;

	localparam int GLYPH_ROWS   = 16;
	localparam int IN_DATA_W    = 56;
	localparam int OUT_DATA_W   = 64;
	localparam int CFG_DATA_W   = 7;
	localparam int CFG_INDEX_W  = 2;

	localparam logic [7:0] SYNC_IDLE        = 8'hC0;
	localparam logic [3:0] CURSOR_FIRST_ROW = 4'd13;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CURSOR_ENABLE = 2'd0,
		REG_CURSOR_COL    = 2'd1,
		REG_CURSOR_ROW    = 2'd2,
		REG_CURSOR_COLOR  = 2'd3
	} cfg_index_t;

	typedef enum logic {
		REQ_RENDER = 1'b0,
		REQ_LOAD   = 1'b1
	} req_type_t;

	// Control that travels with a render transfer while the glyph row is read.
	typedef struct packed {
		logic       blank;
		logic       solid;
		logic [3:0] solid_color;
		logic       code_ok;
		logic [3:0] fg;
		logic [3:0] bg;
	} cell_ctrl_t;

	function automatic logic [7:0] palette(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'hC0;
			4'd1:    c = 8'hC2;
			4'd2:    c = 8'hC8;
			4'd3:    c = 8'hCA;
			4'd4:    c = 8'hE0;
			4'd5:    c = 8'hE2;
			4'd6:    c = 8'hE8;
			4'd7:    c = 8'hEA;
			4'd8:    c = 8'hC0;
			4'd9:    c = 8'hC3;
			4'd10:   c = 8'hCC;
			4'd11:   c = 8'hCF;
			4'd12:   c = 8'hF0;
			4'd13:   c = 8'hF3;
			4'd14:   c = 8'hFC;
			default: c = 8'hFF;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== design/tmcr_font_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmcr_font_mem
// Font store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmcr_font_mem #(
	parameter int DEPTH = tmcr_pkg::FONT_CHARS_DEF * tmcr_pkg::GLYPH_ROWS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/tmcr_pixel.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmcr_pixel
// Expands one glyph row into eight pixel bytes through the colour palette.
// ----------------------------------------------------------------------------
module tmcr_pixel (
	input  wire tmcr_pkg::cell_ctrl_t ctrl,
	input  wire logic [7:0]           glyph,
	output logic [tmcr_pkg::OUT_DATA_W-1:0] pixels
);

	import tmcr_pkg::*;

	logic [7:0] bits;
	logic [7:0] fg_c;
	logic [7:0] bg_c;
	logic [7:0] solid_c;

	assign bits    = ctrl.code_ok ? glyph : 8'h00;
	assign fg_c    = palette(ctrl.fg);
	assign bg_c    = palette(ctrl.bg);
	assign solid_c = palette(ctrl.solid_color);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			if (ctrl.blank) begin
				pixels[8*i +: 8] = SYNC_IDLE;
			end else if (ctrl.solid) begin
				pixels[8*i +: 8] = solid_c;
			end else begin
				pixels[8*i +: 8] = bits[i] ? fg_c : bg_c;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/text_mode_cell_renderer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_mode_cell_renderer
// Character generator for an 8x16 text mode with a loadable font store.
// ----------------------------------------------------------------------------
// One transfer is taken every cycle while s_tready is high. A load transfer
// writes one font byte in the cycle it is taken and gives no result. A render
// transfer reads its glyph row from the font store into the registered read
// stage, and its eight pixel bytes are then registered in the output register
// once that register is free. The font store has one write and one read port;
// s_tready follows m_tready combinationally when both the read stage and the
// output register are full.
module text_mode_cell_renderer #(
	parameter int MAX_COLUMNS = tmcr_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = tmcr_pkg::MAX_ROWS_DEF,
	parameter int FONT_CHARS  = tmcr_pkg::FONT_CHARS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [tmcr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tmcr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// scan_line[9:0], column[16:10], char_code[24:17], attribute[32:25],
	// font_addr[44:33], font_data[52:45], zero fill[55:53]
	input  wire logic [tmcr_pkg::IN_DATA_W-1:0]   s_tdata,
	// req_type[0]
	input  wire logic [0:0]                       s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// pixels[63:0]
	output logic [tmcr_pkg::OUT_DATA_W-1:0]       m_tdata
);

	import tmcr_pkg::*;

	localparam int FONT_DEPTH = FONT_CHARS * GLYPH_ROWS;
	localparam int FA_W       = $clog2(FONT_DEPTH);

	logic       cursor_enable_q;
	logic [6:0] cursor_col_q;
	logic [5:0] cursor_row_q;
	logic [3:0] cursor_color_q;

	logic [9:0]  scan_line;
	logic [6:0]  column;
	logic [7:0]  char_code;
	logic [7:0]  attribute;
	logic [11:0] font_addr;
	logic [7:0]  font_data;
	logic [5:0]  text_row;
	logic [3:0]  glyph_row;
	logic [11:0] read_addr;

	logic       accept;
	logic       render_acc;
	logic       load_we;
	logic       out_free;
	logic       s1_adv;
	logic       s1_valid_q;
	cell_ctrl_t ctrl_s1;
	cell_ctrl_t ctrl_in;
	logic [7:0] glyph_s1;
	logic [OUT_DATA_W-1:0] pixels;

	assign scan_line = s_tdata[9:0];
	assign column    = s_tdata[16:10];
	assign char_code = s_tdata[24:17];
	assign attribute = s_tdata[32:25];
	assign font_addr = s_tdata[44:33];
	assign font_data = s_tdata[52:45];
	assign text_row  = scan_line[9:4];
	assign glyph_row = scan_line[3:0];
	assign read_addr = {char_code, glyph_row};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_enable_q <= 1'b1;
			cursor_col_q    <= 7'd0;
			cursor_row_q    <= 6'd0;
			cursor_color_q  <= 4'd7;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				REG_CURSOR_ENABLE: cursor_enable_q <= cfg_data[0];
				REG_CURSOR_COL:    cursor_col_q    <= cfg_data[6:0];
				REG_CURSOR_ROW:    cursor_row_q    <= cfg_data[5:0];
				REG_CURSOR_COLOR:  cursor_color_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign out_free   = !m_tvalid || m_tready;
	assign s1_adv     = s1_valid_q && out_free;
	assign s_tready   = !s1_valid_q || out_free;
	assign accept     = s_tvalid && s_tready;
	assign render_acc = accept && (req_type_t'(s_tuser[0]) == REQ_RENDER);
	assign load_we    = accept && (req_type_t'(s_tuser[0]) == REQ_LOAD)
		&& ({1'b0, font_addr} < 13'(FONT_DEPTH));

	always_comb begin
		ctrl_in.blank = ({2'b00, column} >= 9'(MAX_COLUMNS))
			|| ({1'b0, text_row} >= 7'(MAX_ROWS));
		ctrl_in.solid = cursor_enable_q && (text_row == cursor_row_q)
			&& (column == cursor_col_q) && (glyph_row >= CURSOR_FIRST_ROW);
		ctrl_in.solid_color = cursor_color_q;
		ctrl_in.code_ok     = {1'b0, char_code} < 9'(FONT_CHARS);
		ctrl_in.fg          = attribute[3:0];
		ctrl_in.bg          = attribute[7:4];
	end

	tmcr_font_mem #(
		.DEPTH(FONT_DEPTH),
		.AW   (FA_W)
	) u_font_mem (
		.clk  (clk),
		.we   (load_we),
		.waddr(font_addr[FA_W-1:0]),
		.wdata(font_data),
		.re   (render_acc),
		.raddr(read_addr[FA_W-1:0]),
		.rdata(glyph_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= render_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (render_acc) begin
			ctrl_s1 <= ctrl_in;
		end
	end

	tmcr_pixel u_pixel (
		.ctrl  (ctrl_s1),
		.glyph (glyph_s1),
		.pixels(pixels)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			m_tdata <= pixels;
		end
	end

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !out_free) |=> s1_valid_q)
		else $error("Read stage lost a cell while the output was stalled");

	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_valid_q && m_tvalid && !m_tready))
		else $error("Input stalled without a full pipeline");

	a_render_s1: assert property (@(posedge clk) disable iff (!arst_n)
		render_acc |=> s1_valid_q)
		else $error("Render transfer did not reach the read stage");

	a_s1_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> m_tvalid)
		else $error("Cell left the read stage without reaching the output");

endmodule
`default_nettype wire

// ===== verif/text_mode_cell_renderer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_cell_renderer_tb
// Self-checking bench for the text mode cell renderer. A short table of
// directed cells is followed by random font loads and cell renders across
// several cursor settings. Each render without fixed pixels in the table is
// predicted from a local copy of the font store and the cursor registers, and
// every pixel transfer is compared in order.
// ----------------------------------------------------------------------------
module text_mode_cell_renderer_tb;
	import tmcr_pkg::*;

	localparam int SCREEN_COLUMNS = MAX_COLUMNS_DEF;
	localparam int SCREEN_ROWS    = MAX_ROWS_DEF;
	localparam int FONT_DEPTH     = FONT_CHARS_DEF * GLYPH_ROWS;
	localparam int PHASE_ITEMS    = 200;

	typedef struct packed {
		req_type_t   req;
		logic [9:0]  line;
		logic [6:0]  col;
		logic [7:0]  code;
		logic [7:0]  attr;
		logic [11:0] faddr;
		logic [7:0]  fdata;
		logic        fixed;
		logic [63:0] pixels;
	} cell_probe_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata   = '0;
	logic [0:0]             s_tuser   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;

	logic [7:0]  font_shadow [0:FONT_DEPTH-1];
	bit          font_loaded [0:FONT_DEPTH-1];
	logic [11:0] loaded_addrs [$];
	logic [63:0] pending_pixels [$];
	logic [63:0] want_pixels;
	cell_probe_t directed_rows [$];

	logic       cur_enable = 1'b1;
	logic [6:0] cur_col    = 7'd0;
	logic [5:0] cur_row    = 6'd0;
	logic [3:0] cur_colour = 4'd7;

	bit steady         = 1'b0;
	int mismatch_count = 0;

	text_mode_cell_renderer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Each colour bit gives level 2, raised to level 3 by the intensity bit.
	function automatic logic [7:0] cga_colour(input logic [3:0] idx);
		logic [1:0] level;
		level = idx[3] ? 2'd3 : 2'd2;
		return {2'b11, idx[2] ? level : 2'd0, idx[1] ? level : 2'd0,
			idx[0] ? level : 2'd0};
	endfunction

	function automatic logic [63:0] render_pixels(input logic [9:0] line,
			input logic [6:0] col, input logic [7:0] code, input logic [7:0] attr);
		logic [5:0]  trow;
		logic [3:0]  grow;
		logic [7:0]  bits;
		logic [63:0] pix;
		trow = line[9:4];
		grow = line[3:0];
		if (col >= SCREEN_COLUMNS || trow >= SCREEN_ROWS)
			return {8{SYNC_IDLE}};
		if (cur_enable && trow == cur_row && col == cur_col && grow >= CURSOR_FIRST_ROW)
			return {8{cga_colour(cur_colour)}};
		bits = (code < FONT_CHARS_DEF) ? font_shadow[{code, grow}] : 8'h00;
		for (int i = 0; i < 8; i++)
			pix[8*i +: 8] = bits[i] ? cga_colour(attr[3:0]) : cga_colour(attr[7:4]);
		return pix;
	endfunction

	task automatic flag_mismatch(input string what);
		if (mismatch_count < 100)
			$display("mismatch at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic write_register(input cfg_index_t idx, input logic [6:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_CURSOR_ENABLE: cur_enable = value[0];
			REG_CURSOR_COL:    cur_col = value[6:0];
			REG_CURSOR_ROW:    cur_row = value[5:0];
			REG_CURSOR_COLOR:  cur_colour = value[3:0];
			default: ;
		endcase
	endtask

	task automatic issue_transfer(input cell_probe_t p);
		if (!steady)
			while ($urandom_range(0, 99) < 31) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		s_tvalid <= 1'b1;
		s_tuser <= p.req;
		s_tdata <= {3'b000, p.fdata, p.faddr, p.attr, p.code, p.col, p.line};
		do @(posedge clk); while (!s_tready);
		if (p.req == REQ_LOAD) begin
			if (p.faddr < FONT_DEPTH) begin
				font_shadow[p.faddr] = p.fdata;
				if (!font_loaded[p.faddr]) begin
					font_loaded[p.faddr] = 1'b1;
					loaded_addrs.push_back(p.faddr);
				end
			end
		end else begin
			pending_pixels.push_back(p.fixed ? p.pixels
				: render_pixels(p.line, p.col, p.code, p.attr));
		end
	endtask

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 31);
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				flag_mismatch($sformatf("unexpected pixels %h", m_tdata));
			end else begin
				want_pixels = pending_pixels.pop_front();
				if (m_tdata !== want_pixels)
					flag_mismatch($sformatf("pixels %h, expected %h", m_tdata, want_pixels));
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAIL text_mode_cell_renderer");
		$finish;
	end

	initial begin : stimulus
		cell_probe_t probe;
		logic [11:0] glyph_addr;
		int          phase;
		int          n;
		int          pick;
		int          tries;

		// Font loads first, then renders of loaded glyphs only.
		directed_rows.push_back('{REQ_LOAD, 10'h000, 7'd0, 8'h00, 8'h00, 12'h000, 8'hFF,
			1'b0, 64'd0});
		directed_rows.push_back('{REQ_LOAD, 10'h000, 7'd0, 8'h00, 8'h00, 12'h00D, 8'h55,
			1'b0, 64'd0});
		directed_rows.push_back('{REQ_LOAD, 10'h000, 7'd0, 8'h00, 8'h00, 12'hFFF, 8'h81,
			1'b0, 64'd0});
		directed_rows.push_back('{REQ_LOAD, 10'h000, 7'd0, 8'h00, 8'h00, 12'hFF0, 8'h00,
			1'b0, 64'd0});
		directed_rows.push_back('{REQ_LOAD, 10'h000, 7'd0, 8'h00, 8'h00, 12'h7A5, 8'hA5,
			1'b0, 64'd0});
		directed_rows.push_back('{REQ_RENDER, 10'h000, 7'd0, 8'h00, 8'hF0, 12'h000, 8'h00,
			1'b0, 64'd0});
		directed_rows.push_back('{REQ_RENDER, 10'h00D, 7'd0, 8'h00, 8'h1F, 12'h000, 8'h00,
			1'b1, 64'hEAEA_EAEA_EAEA_EAEA});
		directed_rows.push_back('{REQ_RENDER, 10'h00F, 7'd0, 8'hFF, 8'h00, 12'h000, 8'h00,
			1'b1, 64'hEAEA_EAEA_EAEA_EAEA});
		directed_rows.push_back('{REQ_RENDER, 10'h00D, 7'd1, 8'h00, 8'h1F, 12'h000, 8'h00,
			1'b0, 64'd0});
		directed_rows.push_back('{REQ_RENDER, 10'h3FF, 7'd127, 8'hFF, 8'hFF, 12'hFFF, 8'hFF,
			1'b1, 64'hC0C0_C0C0_C0C0_C0C0});
		directed_rows.push_back('{REQ_RENDER, 10'h300, 7'd0, 8'h00, 8'h7E, 12'h000, 8'h00,
			1'b1, 64'hC0C0_C0C0_C0C0_C0C0});
		directed_rows.push_back('{REQ_RENDER, 10'h2FF, 7'd127, 8'hFF, 8'h9E, 12'h000, 8'h00,
			1'b0, 64'd0});
		directed_rows.push_back('{REQ_RENDER, 10'h00F, 7'd5, 8'hFF, 8'hFF, 12'h000, 8'h00,
			1'b0, 64'd0});
		directed_rows.push_back('{REQ_RENDER, 10'h035, 7'd64, 8'h7A, 8'h4C, 12'h000, 8'h00,
			1'b0, 64'd0});
		directed_rows.push_back('{REQ_RENDER, 10'h100, 7'd0, 8'hFF, 8'hA3, 12'h000, 8'h00,
			1'b0, 64'd0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			issue_transfer(directed_rows[k]);

		for (phase = 0; phase < 6; phase++) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while (pending_pixels.size() != 0);
			repeat (4) @(posedge clk);
			case (phase)
				0: begin
					write_register(REG_CURSOR_ENABLE, 7'd0);
					write_register(REG_CURSOR_COL, 7'd127);
					write_register(REG_CURSOR_ROW, 7'd63);
					write_register(REG_CURSOR_COLOR, 7'd0);
				end
				1: begin
					write_register(REG_CURSOR_ENABLE, 7'd1);
					write_register(REG_CURSOR_COL, 7'd127);
					write_register(REG_CURSOR_ROW, 7'd47);
					write_register(REG_CURSOR_COLOR, 7'd15);
				end
				2: begin
					write_register(REG_CURSOR_COL, 7'd0);
					write_register(REG_CURSOR_ROW, 7'd0);
					write_register(REG_CURSOR_COLOR, 7'd8);
				end
				3: begin
					// Raw seven-bit values, so the upper bits must be dropped.
					write_register(REG_CURSOR_ENABLE, 7'($urandom_range(0, 127)));
					write_register(REG_CURSOR_COL, 7'($urandom_range(0, 127)));
					write_register(REG_CURSOR_ROW, 7'($urandom_range(0, 127)));
					write_register(REG_CURSOR_COLOR, 7'($urandom_range(0, 127)));
				end
				4: begin
					write_register(REG_CURSOR_ENABLE, 7'd1);
					write_register(REG_CURSOR_COL, 7'($urandom_range(0, 127)));
					write_register(REG_CURSOR_ROW, 7'($urandom_range(0, 47)));
					write_register(REG_CURSOR_COLOR, 7'($urandom_range(0, 15)));
				end
				default: begin
					write_register(REG_CURSOR_ENABLE, 7'd1);
					write_register(REG_CURSOR_COL, 7'd64);
					write_register(REG_CURSOR_ROW, 7'd20);
					write_register(REG_CURSOR_COLOR, 7'd7);
				end
			endcase
			cfg_we <= 1'b0;
			steady = (phase == 2);

			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 1 && n == PHASE_ITEMS / 2) begin
					s_tvalid <= 1'b0;
					do @(posedge clk); while (pending_pixels.size() != 0);
				end
				pick = $urandom_range(0, 99);
				probe.fixed = 1'b0;
				probe.pixels = '0;
				probe.attr = 8'($urandom_range(0, 255));
				probe.faddr = 12'($urandom_range(0, FONT_DEPTH - 1));
				probe.fdata = 8'($urandom_range(0, 255));
				if (pick < 30) begin
					probe.req = REQ_LOAD;
					probe.line = 10'($urandom_range(0, 1023));
					probe.col = 7'($urandom_range(0, 127));
					probe.code = 8'($urandom_range(0, 255));
				end else begin
					probe.req = REQ_RENDER;
					glyph_addr = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
					if (pick < 48)
						for (tries = 0; tries < 8 && glyph_addr[3:0] < CURSOR_FIRST_ROW; tries++)
							glyph_addr = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
					probe.code = glyph_addr[11:4];
					if (pick < 48) begin
						probe.line = {cur_row, glyph_addr[3:0]};
						probe.col = cur_col;
					end else if (pick < 58) begin
						probe.line = {6'($urandom_range(SCREEN_ROWS, 63)), glyph_addr[3:0]};
						probe.col = 7'($urandom_range(0, 127));
					end else begin
						probe.line = {6'($urandom_range(0, SCREEN_ROWS - 1)), glyph_addr[3:0]};
						probe.col = 7'($urandom_range(0, 127));
					end
				end
				issue_transfer(probe);
			end
		end

		s_tvalid <= 1'b0;
		steady = 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_pixels.size() == 0)
			$display("PASS text_mode_cell_renderer");
		else
			$display("FAIL text_mode_cell_renderer");
		$finish;
	end

endmodule
